/* sv/sstg_pkg.sv */
package sstg_pkg;

	// Line geometry
	localparam int LINE_WIDTH = 320;
	localparam int LINE_COUNT = 240;
	localparam int PIX_W      = $clog2(LINE_WIDTH);
	localparam int LINE_W     = $clog2(LINE_COUNT);

	// Field and storage widths
	localparam int COLOR_W = 8;
	localparam int TONE_W  = 12;
	localparam int SEG_W   = 3;
	localparam int STORE_W = 2 * COLOR_W;
	localparam int RATE_W  = 17;
	localparam int LEN_W   = 14;
	localparam int CNT_W   = 4;
	localparam int SEG_NUM = 6;
	localparam int SEG_IDX_W = $clog2(SEG_NUM);

	// Sample rate limits and reset value
	localparam int RATE_DEFAULT = 48000;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(RATE_DEFAULT);
	localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(8000);
	localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(96000);

	typedef enum logic [SEG_W-1:0] {
		SEG_SYNC       = 3'd0,
		SEG_SYNC_PORCH = 3'd1,
		SEG_LUMA       = 3'd2,
		SEG_SEPARATOR  = 3'd3,
		SEG_PORCH      = 3'd4,
		SEG_CHROMA     = 3'd5
	} segment_t;

	typedef logic [LEN_W-1:0] len_arr_t [SEG_NUM];

	// Segment length is (LEN_MUL * rate + LEN_ADD) / 1000, or / 2000 where LEN_BY_2000 is set.
	localparam logic [6:0]  LEN_MUL [SEG_NUM] = '{7'd9, 7'd3, 7'd88, 7'd9, 7'd3, 7'd44};
	localparam logic [10:0] LEN_ADD [SEG_NUM] =
		'{11'd999, 11'd999, 11'd0, 11'd1999, 11'd1999, 11'd0};
	localparam logic [SEG_NUM-1:0] LEN_BY_2000 = 6'b011000;

	localparam len_arr_t LEN_RESET = '{
		LEN_W'((9 * RATE_DEFAULT + 999) / 1000),
		LEN_W'((3 * RATE_DEFAULT + 999) / 1000),
		LEN_W'((88 * RATE_DEFAULT) / 1000),
		LEN_W'((9 * RATE_DEFAULT + 1999) / 2000),
		LEN_W'((3 * RATE_DEFAULT + 1999) / 2000),
		LEN_W'((44 * RATE_DEFAULT) / 1000)
	};

	// Numerator of the length division and the reciprocal of 125.
	// Dividing by 1000 is a shift by three followed by a division by 125.
	localparam int NUM_W       = 24;
	localparam int SH_W        = NUM_W - 3;
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 35;
	localparam int PROD_W      = SH_W + RECIP_W;
	// ceil(2^35 / 125)
	localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;

	// Fixed tones in hertz
	localparam logic [TONE_W-1:0] TONE_SYNC  = 12'd1200;
	localparam logic [TONE_W-1:0] TONE_BLACK = 12'd1500;
	localparam logic [TONE_W-1:0] TONE_PORCH = 12'd1900;
	localparam logic [TONE_W-1:0] TONE_WHITE = 12'd2300;

	typedef logic [TONE_W-1:0] tone_lut_t [2**COLOR_W];

	function automatic tone_lut_t build_tone_lut();
		tone_lut_t lut;
		for (int c = 0; c < 2**COLOR_W; c++) begin
			lut[c] = TONE_W'(1500 + (c * 800) / 255);
		end
		return lut;
	endfunction

	localparam tone_lut_t TONE_LUT = build_tone_lut();

	typedef struct packed {
		logic             busy;
		logic             realign;
		logic [LEN_W-1:0] acc;
		logic [PIX_W-1:0] idx;
	} timing_status_t;

endpackage

/* sv/sstv_scanline_tone_generator_top.sv */
// Robot 36 scan-line tone generator. Load items (operation 0) convert RGB to Y and the
// line's chroma (Cr on even lines, Cb on odd lines) and write the next position of a
// one-line store; tick items (operation 1) each return the tone of one audio sample,
// walking sync, sync porch, luma, separator, porch and chroma with segment lengths set by
// sample_rate. The block takes one item every clock while in_ready is high; a tick's result
// passes from stage 1 through stage 2 to the output register, the line store being a
// synchronous RAM read one stage after the scan state is updated. A write of sample_rate
// holds in_ready low during the write cycle and until the timing sequence is done, while
// a multiplier and a reciprocal multiplier shared by all six segments recompute the
// segment lengths and a bit-serial divider realigns the pixel position within the
// current segment.
module sstv_scanline_tone_generator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sstg_pkg::RATE_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [sstg_pkg::COLOR_W-1:0]  red,
	input  logic [sstg_pkg::COLOR_W-1:0]  green,
	input  logic [sstg_pkg::COLOR_W-1:0]  blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sstg_pkg::TONE_W-1:0]   tone_frequency,
	output logic [sstg_pkg::SEG_W-1:0]    segment,
	output logic                          line_end,
	output logic                          image_end
);
	import sstg_pkg::*;

	// Scan state
	segment_t               seg_q;
	logic [LEN_W-1:0]       sin_q;
	logic [LEN_W-1:0]       acc_q;
	logic [PIX_W-1:0]       idx_q;
	logic [PIX_W-1:0]       load_pos_q;
	logic [LINE_W-1:0]      line_q;

	// Stage 1
	logic                   vld_s1;
	logic                   tick_s1;
	logic [COLOR_W-1:0]     red_s1;
	logic [COLOR_W-1:0]     green_s1;
	logic [COLOR_W-1:0]     blue_s1;
	logic                   even_s1;
	logic [PIX_W-1:0]       addr_s1;
	segment_t               seg_s1;
	logic [TONE_W-1:0]      tone_s1;
	logic                   video_s1;
	logic                   lend_s1;
	logic                   iend_s1;

	// Stage 2
	logic                   vld_s2;
	segment_t               seg_s2;
	logic [TONE_W-1:0]      tone_s2;
	logic                   video_s2;
	logic                   lend_s2;
	logic                   iend_s2;

	// Output register
	logic                   out_vld_q;
	logic [TONE_W-1:0]      tone_q;
	segment_t               seg_out_q;
	logic                   lend_q;
	logic                   iend_q;

	len_arr_t               seg_len;
	timing_status_t         tstat;
	logic [STORE_W-1:0]     ram_rdata;

	logic                   en_out;
	logic                   en_s2;
	logic                   en_s1;
	logic                   accept;
	logic                   tick_acc;
	logic                   load_acc;

	logic                   even;
	logic [LEN_W-1:0]       cur_len;
	logic                   seg_last;
	logic                   over;
	logic                   video;
	logic [PIX_W-1:0]       pix;
	logic [LEN_W:0]         acc_sum;
	logic                   acc_wrap;
	logic                   line_last;
	logic [TONE_W-1:0]      fixed_tone;

	logic [15:0]            y_sum;
	logic [15:0]            cr_sum;
	logic [15:0]            cb_sum;
	logic [COLOR_W-1:0]     luma;
	logic [COLOR_W-1:0]     chroma;
	logic                   ram_we;
	logic                   ram_re;
	logic [COLOR_W-1:0]     sel_byte;

	sstg_timing u_timing (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.seg        (seg_q),
		.sample_idx (sin_q),
		.seg_len    (seg_len),
		.status     (tstat)
	);

	// Each stage moves on when the one after it is empty or moving.
	assign en_out   = !out_vld_q || out_ready;
	assign en_s2    = !vld_s2 || en_out;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1 && !tstat.busy && !cfg_we;
	assign accept   = in_valid && in_ready;
	assign tick_acc = accept && operation;
	assign load_acc = accept && !operation;

	assign even      = !line_q[0];
	assign cur_len   = seg_len[seg_q];
	assign seg_last  = ({1'b0, sin_q} + 1'b1) >= {1'b0, cur_len};
	assign over      = sin_q >= cur_len;
	assign video     = (seg_q == SEG_LUMA) || (seg_q == SEG_CHROMA);
	assign pix       = over ? PIX_W'(LINE_WIDTH - 1) : idx_q;
	assign acc_sum   = {1'b0, acc_q} + (LEN_W + 1)'(LINE_WIDTH);
	assign acc_wrap  = acc_sum >= {1'b0, cur_len};
	assign line_last = ({1'b0, line_q} + 1'b1) >= (LINE_W + 1)'(LINE_COUNT);

	always_comb begin
		case (seg_q)
			SEG_SYNC:       fixed_tone = TONE_SYNC;
			SEG_SYNC_PORCH: fixed_tone = TONE_BLACK;
			SEG_SEPARATOR:  fixed_tone = even ? TONE_BLACK : TONE_WHITE;
			SEG_PORCH:      fixed_tone = TONE_PORCH;
			default:        fixed_tone = TONE_BLACK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q      <= SEG_SYNC;
			sin_q      <= '0;
			acc_q      <= '0;
			idx_q      <= '0;
			load_pos_q <= '0;
			line_q     <= '0;
		end else if (tstat.realign) begin
			acc_q <= tstat.acc;
			idx_q <= tstat.idx;
		end else if (load_acc) begin
			if (load_pos_q == PIX_W'(LINE_WIDTH - 1)) begin
				load_pos_q <= '0;
			end else begin
				load_pos_q <= load_pos_q + 1'b1;
			end
		end else if (tick_acc) begin
			if (seg_last) begin
				sin_q <= '0;
				acc_q <= '0;
				idx_q <= '0;
				if (seg_q == SEG_CHROMA) begin
					seg_q      <= SEG_SYNC;
					load_pos_q <= '0;
					line_q     <= line_last ? '0 : line_q + 1'b1;
				end else begin
					seg_q <= segment_t'(seg_q + 1'b1);
				end
			end else begin
				sin_q <= sin_q + 1'b1;
				if (video) begin
					if (acc_wrap) begin
						acc_q <= LEN_W'(acc_sum - {1'b0, cur_len});
						idx_q <= idx_q + 1'b1;
					end else begin
						acc_q <= acc_sum[LEN_W-1:0];
					end
				end
			end
		end
	end

	// Stage 1: loads convert color and write the store; ticks read it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && accept) begin
			tick_s1  <= operation;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			even_s1  <= even;
			addr_s1  <= operation ? pix : load_pos_q;
			seg_s1   <= seg_q;
			tone_s1  <= fixed_tone;
			video_s1 <= video;
			lend_s1  <= seg_last && (seg_q == SEG_CHROMA);
			iend_s1  <= seg_last && (seg_q == SEG_CHROMA) && line_last;
		end
	end

	// The offset 32896 keeps the chroma sums positive; it folds in the rounding and +128.
	assign y_sum  = 16'(red_s1) * 16'd66 + 16'(green_s1) * 16'd129
		+ 16'(blue_s1) * 16'd25 + 16'd128;
	assign cr_sum = 16'd32896 + 16'(red_s1) * 16'd112 - 16'(green_s1) * 16'd94
		- 16'(blue_s1) * 16'd18;
	assign cb_sum = 16'd32896 + 16'(blue_s1) * 16'd112 - 16'(red_s1) * 16'd38
		- 16'(green_s1) * 16'd74;
	assign luma   = y_sum[15:8] + 8'd16;
	assign chroma = even_s1 ? cr_sum[15:8] : cb_sum[15:8];

	assign ram_we = vld_s1 && !tick_s1 && en_s2;
	assign ram_re = vld_s1 && tick_s1 && video_s1 && en_s2;

	sstg_line_ram #(
		.DEPTH (LINE_WIDTH),
		.WIDTH (STORE_W)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata ({luma, chroma}),
		.re    (ram_re),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// Stage 2: tick items only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1 && tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1 && tick_s1) begin
			seg_s2   <= seg_s1;
			tone_s2  <= tone_s1;
			video_s2 <= video_s1;
			lend_s2  <= lend_s1;
			iend_s2  <= iend_s1;
		end
	end

	assign sel_byte = (seg_s2 == SEG_CHROMA) ? ram_rdata[COLOR_W-1:0]
		: ram_rdata[STORE_W-1:COLOR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en_out) begin
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && vld_s2) begin
			tone_q    <= video_s2 ? TONE_LUT[sel_byte] : tone_s2;
			seg_out_q <= seg_s2;
			lend_q    <= lend_s2;
			iend_q    <= iend_s2;
		end
	end

	assign out_valid      = out_vld_q;
	assign tone_frequency = tone_q;
	assign segment        = seg_out_q;
	assign line_end       = lend_q;
	assign image_end      = iend_q;

	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		load_pos_q < PIX_W'(LINE_WIDTH))
		else $error("load position ran past the line");

	a_line_end_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> segment == SEG_CHROMA)
		else $error("line end flagged outside the chroma segment");

	a_image_end_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> line_end)
		else $error("image end flagged without line end");

endmodule

/* sv/sstg_line_ram.sv */
module sstg_line_ram #(
	parameter int DEPTH = 320,
	parameter int WIDTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/sstg_timing.sv */
module sstg_timing (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sstg_pkg::RATE_W-1:0]   cfg_wdata,
	input  sstg_pkg::segment_t            seg,
	input  logic [sstg_pkg::LEN_W-1:0]    sample_idx,
	output sstg_pkg::len_arr_t            seg_len,
	output sstg_pkg::timing_status_t      status
);
	import sstg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LEN  = 3'b010,
		ST_DIV  = 3'b100
	} seq_state_t;

	localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(2 * SEG_NUM - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PIX_W);
	localparam int P_W = LEN_W + PIX_W;

	seq_state_t             st_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [RATE_W-1:0]      rate_q;
	logic [LEN_W-1:0]       len_q [SEG_NUM];
	logic [NUM_W-1:0]       num_q;
	logic [LEN_W-1:0]       rem_q;
	logic [PIX_W-1:0]       quo_q;
	logic [PIX_W-1:0]       dvd_q;

	logic [SEG_IDX_W-1:0]   k;
	logic [RATE_W-1:0]      rate_c;
	logic [NUM_W-1:0]       num_c;
	logic [SH_W-1:0]        num_sh;
	logic [PROD_W-1:0]      prod_c;
	logic [LEN_W-1:0]       len_c;
	logic [LEN_W-1:0]       cur_len;
	logic [P_W-1:0]         pnum_c;
	logic [LEN_W:0]         trial;
	logic                   ge;

	assign k = cnt_q[SEG_IDX_W:1];

	always_comb begin
		if (rate_q < RATE_MIN) begin
			rate_c = RATE_MIN;
		end else if (rate_q > RATE_MAX) begin
			rate_c = RATE_MAX;
		end else begin
			rate_c = rate_q;
		end
	end

	// Even count: form the numerator. Odd count: divide it and store the length.
	assign num_c  = NUM_W'(LEN_MUL[k]) * NUM_W'(rate_c) + NUM_W'(LEN_ADD[k]);
	assign num_sh = LEN_BY_2000[k] ? SH_W'(num_q >> 4) : SH_W'(num_q >> 3);
	assign prod_c = PROD_W'(num_sh) * PROD_W'(RECIP_125);
	assign len_c  = prod_c[RECIP_SHIFT +: LEN_W];

	// Restoring division of sample_idx * LINE_WIDTH by the current segment length,
	// one quotient bit per cycle, to realign the pixel stepper after a rate change.
	assign cur_len = len_q[seg];
	assign pnum_c  = P_W'(sample_idx) * P_W'(LINE_WIDTH);
	assign trial   = {rem_q, dvd_q[PIX_W-1]};
	assign ge      = trial >= {1'b0, cur_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
			rate_q <= RATE_RESET;
			len_q  <= LEN_RESET;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				rate_q <= cfg_wdata;
				st_q   <= ST_LEN;
				cnt_q  <= '0;
			end else begin
				case (st_q)
					ST_LEN: begin
						if (cnt_q[0]) begin
							len_q[k] <= len_c;
						end
						if (cnt_q == LEN_LAST) begin
							st_q  <= ST_DIV;
							cnt_q <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					ST_DIV: begin
						if (cnt_q == DIV_LAST) begin
							st_q   <= ST_IDLE;
							cnt_q  <= '0;
							done_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					default: begin
						st_q  <= ST_IDLE;
						cnt_q <= '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_LEN && !cnt_q[0]) begin
			num_q <= num_c;
		end
		if (st_q == ST_DIV) begin
			if (cnt_q == '0) begin
				rem_q <= pnum_c[P_W-1:PIX_W];
				dvd_q <= pnum_c[PIX_W-1:0];
				quo_q <= '0;
			end else begin
				rem_q <= ge ? LEN_W'(trial - {1'b0, cur_len}) : trial[LEN_W-1:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[PIX_W-2:0], ge};
			end
		end
	end

	assign seg_len        = len_q;
	assign status.busy    = (st_q != ST_IDLE) || done_q;
	assign status.realign = done_q;
	assign status.acc     = rem_q;
	assign status.idx     = quo_q;

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> status.busy)
		else $error("rate write did not start the length sequence");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("realign strobe lasted more than one cycle");

endmodule

/* bench/tb_sstv_scanline_tone_generator_top.sv */
module tb_sstv_scanline_tone_generator_top;
	import sstg_pkg::*;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic [TONE_W-1:0] tone;
		segment_t          seg;
		logic              line_end;
		logic              image_end;
	} scan_sample_t;

	typedef struct packed {
		op_t                op;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               typed;
		scan_sample_t       want;
	} stim_row_t;

	localparam scan_sample_t NO_WANT = '0;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	// Luma length in samples at the lowest rate.
	localparam int LUMA_LEN_MIN = (88 * 8000) / 1000;

	// Only the first three tones after reset are typed in; the rest come from the predictor.
	localparam stim_row_t DIRECTED [14] = '{
		'{OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, '{12'd1200, SEG_SYNC, 1'b0, 1'b0}},
		'{OP_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{12'd1200, SEG_SYNC, 1'b0, 1'b0}},
		'{OP_LOAD, 8'h00, 8'h00, 8'h00, 1'b0, NO_WANT},
		'{OP_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WANT},
		'{OP_LOAD, 8'hFF, 8'h00, 8'h00, 1'b0, NO_WANT},
		'{OP_LOAD, 8'h00, 8'hFF, 8'h00, 1'b0, NO_WANT},
		'{OP_LOAD, 8'h00, 8'h00, 8'hFF, 1'b0, NO_WANT},
		'{OP_LOAD, 8'hFF, 8'hFF, 8'h00, 1'b0, NO_WANT},
		'{OP_LOAD, 8'h00, 8'hFF, 8'hFF, 1'b0, NO_WANT},
		'{OP_LOAD, 8'hFF, 8'h00, 8'hFF, 1'b0, NO_WANT},
		'{OP_LOAD, 8'h55, 8'hAA, 8'h55, 1'b0, NO_WANT},
		'{OP_LOAD, 8'hAA, 8'h55, 8'hAA, 1'b0, NO_WANT},
		'{OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1, '{12'd1200, SEG_SYNC, 1'b0, 1'b0}},
		'{OP_TICK, 8'h12, 8'h34, 8'h56, 1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RATE_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [COLOR_W-1:0] red = '0;
	logic [COLOR_W-1:0] green = '0;
	logic [COLOR_W-1:0] blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TONE_W-1:0] tone_frequency;
	logic [SEG_W-1:0] segment;
	logic line_end;
	logic image_end;

	sstv_scanline_tone_generator_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tone_frequency (tone_frequency),
		.segment        (segment),
		.line_end       (line_end),
		.image_end      (image_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the scan state and the rate register.
	logic [RATE_W-1:0]  rate_reg = RATE_W'(48000);
	logic [STORE_W-1:0] line_store [LINE_WIDTH];
	logic [PIX_W-1:0]   load_pos = '0;
	logic [LINE_W-1:0]  line_num = '0;
	logic [SEG_W-1:0]   cur_seg = '0;
	logic [LEN_W-1:0]   samp_idx = '0;

	scan_sample_t pending_tones [$];
	scan_sample_t got_tone;
	scan_sample_t exp_tone;
	int  fails = 0;
	bit  idle_on = 1'b1;
	bit  hold_req = 1'b0;

	function automatic int unsigned seg_len(segment_t seg);
		int unsigned sr;
		sr = rate_reg;
		if (sr < 8000) sr = 8000;
		else if (sr > 96000) sr = 96000;
		case (seg)
			SEG_SYNC:       return (9 * sr + 999) / 1000;
			SEG_SYNC_PORCH: return (3 * sr + 999) / 1000;
			SEG_LUMA:       return (88 * sr) / 1000;
			SEG_SEPARATOR:  return (9 * sr + 1999) / 2000;
			SEG_PORCH:      return (3 * sr + 1999) / 2000;
			default:        return (44 * sr) / 1000;
		endcase
	endfunction

	function automatic logic [TONE_W-1:0] color_tone(logic [COLOR_W-1:0] c);
		int unsigned cv;
		cv = c;
		return TONE_W'(1500 + (cv * 800) / 255);
	endfunction

	function automatic void store_pixel(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
			logic [COLOR_W-1:0] b);
		int ri, gi, bi, y, cs;
		logic [COLOR_W-1:0] chroma;
		ri = r;
		gi = g;
		bi = b;
		y = ((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16;
		if (!line_num[0]) cs = 112 * ri - 94 * gi - 18 * bi;
		else cs = -38 * ri - 74 * gi + 112 * bi;
		// The offset keeps the shifted value positive, so the shift floors.
		chroma = COLOR_W'((cs + 128 + 32768) >>> 8);
		if (load_pos >= LINE_WIDTH) load_pos = '0;
		line_store[load_pos] = {COLOR_W'(y), chroma};
		load_pos = load_pos + 1'b1;
		if (load_pos >= LINE_WIDTH) load_pos = '0;
	endfunction

	function automatic scan_sample_t next_sample_tone();
		scan_sample_t s;
		segment_t seg;
		int unsigned n, i, pix;
		seg = (cur_seg > SEG_CHROMA) ? SEG_CHROMA : segment_t'(cur_seg);
		n = seg_len(seg);
		i = samp_idx;
		if (i >= n) i = n - 1;
		pix = (i * LINE_WIDTH) / n;
		if (pix >= LINE_WIDTH) pix = LINE_WIDTH - 1;
		s.seg = seg;
		s.line_end = 1'b0;
		s.image_end = 1'b0;
		case (seg)
			SEG_SYNC:       s.tone = 12'd1200;
			SEG_SYNC_PORCH: s.tone = 12'd1500;
			SEG_SEPARATOR:  s.tone = line_num[0] ? 12'd2300 : 12'd1500;
			SEG_PORCH:      s.tone = 12'd1900;
			SEG_LUMA:       s.tone = color_tone(line_store[pix][STORE_W-1:COLOR_W]);
			default:        s.tone = color_tone(line_store[pix][COLOR_W-1:0]);
		endcase
		if (i + 1 >= n) begin
			samp_idx = '0;
			if (seg == SEG_CHROMA) begin
				s.line_end = 1'b1;
				cur_seg = SEG_SYNC;
				load_pos = '0;
				if (int'(line_num) + 1 >= LINE_COUNT) begin
					s.image_end = 1'b1;
					line_num = '0;
				end else begin
					line_num = line_num + 1'b1;
				end
			end else begin
				cur_seg = seg + 1'b1;
			end
		end else begin
			samp_idx = LEN_W'(i + 1);
		end
		return s;
	endfunction

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(15, 80);
		return $urandom_range(1, 3);
	endfunction

	// Full-scale values come up often so that chroma reaches its extremes on both line kinds.
	function automatic logic [COLOR_W-1:0] rand_color();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return COLOR_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(op_t op, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
			logic [COLOR_W-1:0] b, logic typed, scan_sample_t want);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (!in_ready);
		if (op == OP_TICK) begin
			got_tone = next_sample_tone();
			pending_tones.push_back(typed ? want : got_tone);
		end else begin
			store_pixel(r, g, b);
		end
	endtask

	task automatic send_random(int unsigned load_pct);
		op_t op;
		op = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_TICK;
		send_item(op, rand_color(), rand_color(), rand_color(), 1'b0, NO_WANT);
	endtask

	task automatic run_phase(int unsigned count, int unsigned load_pct, int hold_at);
		for (int k = 0; k < count; k++) begin
			if (k == hold_at) hold_req = 1'b1;
			send_random(load_pct);
		end
	endtask

	// The rate is only changed with the block drained and no item offered.
	task automatic write_rate(logic [RATE_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_tones.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_reg = value;
	endtask

	task automatic compare_field(string name, logic [TONE_W-1:0] want_v,
			logic [TONE_W-1:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_tones.size() == 0) begin
				$error("tone item with none expected: tone %0d segment %0d",
					tone_frequency, segment);
				fails++;
			end else begin
				exp_tone = pending_tones.pop_front();
				compare_field("tone_frequency", exp_tone.tone, tone_frequency);
				compare_field("segment", TONE_W'(exp_tone.seg), TONE_W'(segment));
				compare_field("line_end", TONE_W'(exp_tone.line_end), TONE_W'(line_end));
				compare_field("image_end", TONE_W'(exp_tone.image_end), TONE_W'(image_end));
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up into its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(3_000_000 * 8);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[k]) begin
			send_item(DIRECTED[k].op, DIRECTED[k].red, DIRECTED[k].green,
				DIRECTED[k].blue, DIRECTED[k].typed, DIRECTED[k].want);
		end
		// Fill the rest of the line before the first luma sample can read the store.
		do send_item(OP_LOAD, rand_color(), rand_color(), rand_color(), 1'b0, NO_WANT);
		while (load_pos != 0);

		// Mostly the lowest rate, so that one whole line fits in the run.
		write_rate('0);
		run_phase(150, 3, 60);
		write_rate('1);
		run_phase(60, 5, -1);
		write_rate(RATE_W'($urandom_range(8000, 96000)));
		run_phase(100, 3, -1);
		write_rate(RATE_W'(7999));
		run_phase(200, 3, -1);

		idle_on = 1'b0;
		run_phase(150, 3, -1);
		idle_on = 1'b1;

		// Step past the low-rate luma length at the top rate, then drop the rate so
		// that the current segment ends on the next sample.
		write_rate(RATE_W'(96001));
		while (int'(samp_idx) < LUMA_LEN_MIN) send_random(0);
		write_rate(RATE_W'(8000));
		while (line_num == '0) send_random(3);
		run_phase(40, 40, -1);

		in_valid <= 1'b0;
		while (pending_tones.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* files.f */
sv/sstg_pkg.sv
sv/sstg_line_ram.sv
sv/sstg_timing.sv
sv/sstv_scanline_tone_generator_top.sv
bench/tb_sstv_scanline_tone_generator_top.sv
